/* sv/sfd_pkg.sv */
// sfd_pkg: shared types and constants for the stick flick detector.
// Holds the stream widths, register indexes, reset values, unit widths, direction codes and cfg_t.
// No dependencies.
`default_nettype none

package sfd_pkg;

    // stream and configuration port widths
    localparam int IN_DATA_W   = 88;
    localparam int OUT_DATA_W  = 24;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEADZONE     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_THRESH  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ARM_THRESH   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIFT_TMO    = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MOD_THRESH   = 8'd4;

    // register reset values
    localparam logic [14:0] DEADZONE_RST    = 15'd0;
    localparam logic [15:0] EDGE_THRESH_RST = 16'd26214;
    localparam logic [15:0] ARM_THRESH_RST  = 16'd11469;
    localparam logic [31:0] DRIFT_TMO_RST   = 32'd350000;
    localparam logic [15:0] MOD_THRESH_RST  = 16'd9830;

    // Q1.15 one
    localparam logic [15:0] MAG_ONE = 16'h8000;

    // square root unit: 32-bit radicand taken as radicand * 2^32
    localparam int SQ_IN_W = 32;
    localparam int ROOT_W  = 32;

    // divider unit
    localparam int NUM_W = 46;
    localparam int DEN_W = 30;
    localparam int QUO_W = 18;

    // eight-way direction codes, clockwise from up
    localparam logic [2:0] DIR_UP         = 3'd0;
    localparam logic [2:0] DIR_UP_RIGHT   = 3'd1;
    localparam logic [2:0] DIR_RIGHT      = 3'd2;
    localparam logic [2:0] DIR_DOWN_RIGHT = 3'd3;
    localparam logic [2:0] DIR_DOWN       = 3'd4;
    localparam logic [2:0] DIR_DOWN_LEFT  = 3'd5;
    localparam logic [2:0] DIR_LEFT       = 3'd6;
    localparam logic [2:0] DIR_UP_LEFT    = 3'd7;

    typedef struct packed {
        logic [14:0] deadzone;
        logic [15:0] edge_threshold;
        logic [15:0] arm_threshold;
        logic [31:0] drift_timeout;
        logic [15:0] modifier_threshold;
    } cfg_t;

endpackage

`default_nettype wire

/* sv/stick_flick_detector.sv */
// stick_flick_detector: radial deadzone stick magnitude and flick gesture detector.
// Takes a new input only when idle, once the previous result has been committed to the
// output register; each item runs through the 32-step square root and 18-step divider.
// aresetn is synchronous, active low: clears detector state, restores register
// defaults, empties the output register. Uses sfd_pkg, sfd_cfg_regs, sfd_isqrt, sfd_div.
`default_nettype none

module stick_flick_detector (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // stick_x, stick_y, step_us, grab_level, trick_level, spin_held, zero fill
    input  logic [sfd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // pad_present
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // flick_direction, grab_modifier, trick_modifier, alt_modifier, magnitude, zero fill
    output logic [sfd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // flick_valid
    output logic [0:0]                          m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_S,
        ST_ROOT,
        ST_PREP,
        ST_DIV,
        ST_COMMIT
    } state_t;

    state_t         state_reg, state_next;
    sfd_pkg::cfg_t  cfg;

    logic in_xfer;
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    sfd_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_wdata),
        .cfg      (cfg)
    );

    // input fields
    logic [15:0] in_x, in_y;
    assign in_x = s_axis_tdata[15:0];
    assign in_y = s_axis_tdata[31:16];

    logic [15:0] ax_in, ay_in;
    assign ax_in = in_x[15] ? (~in_x + 16'd1) : in_x;
    // y is negated stick_y; negated full-scale negative saturates
    assign ay_in = (in_y == 16'h8000) ? 16'h7FFF : (in_y[15] ? (~in_y + 16'd1) : in_y);

    logic [15:0] ax_reg, ay_reg;
    logic        x_pos_reg, y_pos_reg, y_nonneg_reg;
    logic [15:0] step_reg, grab_reg, trick_reg;
    logic        pad_reg, spin_reg;
    logic [31:0] sqx_reg, sqy_reg, sum2_reg;
    logic [2:0]  dir_reg;
    logic [15:0] mag_reg;

    // shared squaring multiplier
    logic [15:0] mul_op;
    logic [31:0] prod;
    always_comb begin
        case (state_reg)
            ST_MUL_X: mul_op = ax_reg;
            ST_MUL_Y: mul_op = ay_reg;
            default:  mul_op = ax_reg + ay_reg;
        endcase
    end
    assign prod = {16'd0, mul_op} * {16'd0, mul_op};

    // square root of (x^2 + y^2) * 2^32
    logic                           sqrt_done;
    logic [sfd_pkg::ROOT_W-1:0]     root;

    sfd_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_MUL_S),
        .radicand (sqx_reg + sqy_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    // deadzone rescale: q = floor(2^14 * (root - 65534 d) / (32767 * (32768 - d)))
    logic [30:0] dz_scaled;
    logic [32:0] above_dz;
    logic [15:0] dz_span;
    logic [30:0] den_full;
    logic [sfd_pkg::NUM_W-1:0] div_num;
    logic [sfd_pkg::DEN_W-1:0] div_den;

    assign dz_scaled = {cfg.deadzone, 16'd0} - {15'd0, cfg.deadzone, 1'b0};
    assign above_dz  = {1'b0, root} - {2'd0, dz_scaled};
    assign div_num   = (!above_dz[32] && (above_dz[31:0] != 32'd0)) ?
                       {above_dz[31:0], 14'd0} : '0;
    assign dz_span   = sfd_pkg::MAG_ONE - {1'b0, cfg.deadzone};
    assign den_full  = {dz_span, 15'd0} - {15'd0, dz_span};
    assign div_den   = den_full[sfd_pkg::DEN_W-1:0];

    logic                           div_done;
    logic [sfd_pkg::QUO_W-1:0]      quo;

    sfd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_PREP),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (quo)
    );

    logic        quo_sat;
    logic [15:0] mag_sat;
    assign quo_sat = quo[17] | quo[16] | (quo[15] & (|quo[14:0]));
    assign mag_sat = quo_sat ? sfd_pkg::MAG_ONE : quo[15:0];

    // eight-way sector
    logic       vert, horiz;
    logic [2:0] dir_calc;
    assign vert  = ({1'b0, sum2_reg} < {sqy_reg, 1'b0}) || ((ax_reg == 16'd0) && (ay_reg == 16'd0));
    assign horiz = ({1'b0, sum2_reg} < {sqx_reg, 1'b0});
    always_comb begin
        if (vert) begin
            dir_calc = y_nonneg_reg ? sfd_pkg::DIR_UP : sfd_pkg::DIR_DOWN;
        end else if (horiz) begin
            dir_calc = x_pos_reg ? sfd_pkg::DIR_RIGHT : sfd_pkg::DIR_LEFT;
        end else if (x_pos_reg) begin
            dir_calc = y_pos_reg ? sfd_pkg::DIR_UP_RIGHT : sfd_pkg::DIR_DOWN_RIGHT;
        end else begin
            dir_calc = y_pos_reg ? sfd_pkg::DIR_UP_LEFT : sfd_pkg::DIR_DOWN_LEFT;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            ax_reg       <= ax_in;
            ay_reg       <= ay_in;
            x_pos_reg    <= !in_x[15] && (in_x != 16'd0);
            y_pos_reg    <= in_y[15];
            y_nonneg_reg <= in_y[15] || (in_y == 16'd0);
            step_reg     <= s_axis_tdata[47:32];
            grab_reg     <= s_axis_tdata[63:48];
            trick_reg    <= s_axis_tdata[79:64];
            spin_reg     <= s_axis_tdata[80];
            pad_reg      <= s_axis_tuser[0];
        end
        if (state_reg == ST_MUL_X) sqx_reg  <= prod;
        if (state_reg == ST_MUL_Y) sqy_reg  <= prod;
        if (state_reg == ST_MUL_S) sum2_reg <= prod;
        if (state_reg == ST_ROOT)  dir_reg  <= dir_calc;
        if (div_done)              mag_reg  <= mag_sat;
    end

    // detector state
    logic        armed_reg, armed_next;
    logic [31:0] armed_time_reg, armed_time_next;
    logic [15:0] last_mag_reg, last_mag_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_user_reg, out_user_next;
    logic [sfd_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic        below_arm, above_edge, over_drift, flick, commit;
    logic [32:0] time_sum;
    logic [31:0] time_sat;
    logic [15:0] mag_out;
    logic        grab_mod, trick_mod;

    assign below_arm  = mag_reg < cfg.arm_threshold;
    assign above_edge = mag_reg > cfg.edge_threshold;
    assign time_sum   = {1'b0, armed_time_reg} + {17'd0, step_reg};
    assign time_sat   = time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
    assign over_drift = time_sat > cfg.drift_timeout;
    assign flick      = pad_reg && !below_arm && armed_reg && above_edge;
    assign mag_out    = pad_reg ? mag_reg : last_mag_reg;
    assign grab_mod   = flick && (grab_reg > cfg.modifier_threshold);
    assign trick_mod  = flick && (trick_reg > cfg.modifier_threshold);

    always_comb begin
        state_next      = state_reg;
        armed_next      = armed_reg;
        armed_time_next = armed_time_reg;
        last_mag_next   = last_mag_reg;
        out_valid_next  = out_valid_reg;
        out_user_next   = out_user_reg;
        out_data_next   = out_data_reg;
        commit          = 1'b0;
        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:   if (in_xfer) state_next = ST_MUL_X;
            ST_MUL_X:  state_next = ST_MUL_Y;
            ST_MUL_Y:  state_next = ST_MUL_S;
            ST_MUL_S:  state_next = ST_ROOT;
            ST_ROOT:   if (sqrt_done) state_next = ST_PREP;
            ST_PREP:   state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_COMMIT;
            ST_COMMIT: begin
                if (!out_valid_reg || m_axis_tready) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
        if (commit) begin
            out_valid_next = 1'b1;
            out_user_next  = flick;
            out_data_next  = {2'b00, mag_out, flick && spin_reg, trick_mod, grab_mod,
                              flick ? dir_reg : sfd_pkg::DIR_UP};
            if (pad_reg) begin
                last_mag_next = mag_reg;
                if (below_arm) begin
                    armed_next      = 1'b1;
                    armed_time_next = 32'd0;
                end else if (armed_reg) begin
                    armed_time_next = time_sat;
                    if (above_edge || over_drift) begin
                        armed_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            armed_reg      <= 1'b0;
            armed_time_reg <= 32'd0;
            last_mag_reg   <= 16'd0;
            out_valid_reg  <= 1'b0;
            out_user_reg   <= 1'b0;
            out_data_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            armed_reg      <= armed_next;
            armed_time_reg <= armed_time_next;
            last_mag_reg   <= last_mag_next;
            out_valid_reg  <= out_valid_next;
            out_user_reg   <= out_user_next;
            out_data_reg   <= out_data_next;
        end
    end

    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tuser[0] = out_user_reg;
    assign m_axis_tdata    = out_data_reg;

`ifndef NO_ASSERTIONS
    a_flick_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && flick) |=> !armed_reg)
        else $error("detector still armed after a flick");

    a_flick_magnitude: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[21:6] != 16'd0))
        else $error("flick reported with zero magnitude");

    a_quiet_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[5:0] == 6'd0))
        else $error("direction or modifiers set without a flick");

    a_root_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> (state_reg == ST_ROOT))
        else $error("square root finished outside its wait state");

    a_quo_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");
`endif

endmodule

`default_nettype wire

/* sv/sfd_cfg_regs.sv */
// sfd_cfg_regs: configuration register file of the stick flick detector.
// Depends on sfd_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module sfd_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [sfd_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]      wr_data,
    output sfd_pkg::cfg_t                       cfg
);

    sfd_pkg::cfg_t cfg_reg;
    sfd_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                sfd_pkg::REG_DEADZONE:    cfg_next.deadzone           = wr_data[14:0];
                sfd_pkg::REG_EDGE_THRESH: cfg_next.edge_threshold     = wr_data[15:0];
                sfd_pkg::REG_ARM_THRESH:  cfg_next.arm_threshold      = wr_data[15:0];
                sfd_pkg::REG_DRIFT_TMO:   cfg_next.drift_timeout      = wr_data;
                sfd_pkg::REG_MOD_THRESH:  cfg_next.modifier_threshold = wr_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deadzone           <= sfd_pkg::DEADZONE_RST;
            cfg_reg.edge_threshold     <= sfd_pkg::EDGE_THRESH_RST;
            cfg_reg.arm_threshold      <= sfd_pkg::ARM_THRESH_RST;
            cfg_reg.drift_timeout      <= sfd_pkg::DRIFT_TMO_RST;
            cfg_reg.modifier_threshold <= sfd_pkg::MOD_THRESH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* sv/sfd_isqrt.sv */
// sfd_isqrt: digit-serial integer square root, floor(sqrt(radicand * 2^32)).
// Radicand shifts out two bits per cycle, one root bit per cycle.
// Depends on sfd_pkg (SQ_IN_W, ROOT_W).
`default_nettype none

module sfd_isqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [sfd_pkg::SQ_IN_W-1:0]     radicand,
    output logic                            done,
    output logic [sfd_pkg::ROOT_W-1:0]      root
);

    localparam int CNT_W = $clog2(sfd_pkg::ROOT_W);
    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(sfd_pkg::ROOT_W - 1);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [sfd_pkg::SQ_IN_W-1:0]    src_reg, src_next;
    logic [sfd_pkg::ROOT_W:0]       rem_reg, rem_next;
    logic [sfd_pkg::ROOT_W-1:0]     root_reg, root_next;

    logic [sfd_pkg::ROOT_W+2:0]     work;
    logic [sfd_pkg::ROOT_W+2:0]     trial;
    logic [sfd_pkg::ROOT_W+2:0]     diff;
    logic                           fits;

    assign work  = {rem_reg, src_reg[sfd_pkg::SQ_IN_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign diff  = work - trial;
    assign fits  = (work >= trial);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        src_next  = src_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = ITER_LAST;
            src_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            src_next  = {src_reg[sfd_pkg::SQ_IN_W-3:0], 2'b00};
            rem_next  = fits ? diff[sfd_pkg::ROOT_W:0] : work[sfd_pkg::ROOT_W:0];
            root_next = {root_reg[sfd_pkg::ROOT_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

/* sv/sfd_div.sv */
// sfd_div: restoring divider, one quotient bit per cycle.
// Divisor sits in a shift register that moves right one bit per step.
// Depends on sfd_pkg (NUM_W, DEN_W, QUO_W).
`default_nettype none

module sfd_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [sfd_pkg::NUM_W-1:0]       num,
    input  logic [sfd_pkg::DEN_W-1:0]       den,
    output logic                            done,
    output logic [sfd_pkg::QUO_W-1:0]       quo
);

    localparam int SH_W  = sfd_pkg::DEN_W + sfd_pkg::QUO_W - 1;
    localparam int CNT_W = $clog2(sfd_pkg::QUO_W);
    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(sfd_pkg::QUO_W - 1);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [sfd_pkg::NUM_W-1:0]      rem_reg, rem_next;
    logic [SH_W-1:0]                dvs_reg, dvs_next;
    logic [sfd_pkg::QUO_W-1:0]      quo_reg, quo_next;

    logic [SH_W:0]                  diff;
    logic                           fits;

    assign diff = {(SH_W + 1 - sfd_pkg::NUM_W)'(0), rem_reg} - {1'b0, dvs_reg};
    assign fits = ~diff[SH_W];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = ITER_LAST;
            rem_next  = num;
            dvs_next  = {den, (sfd_pkg::QUO_W - 1)'(0)};
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = fits ? diff[sfd_pkg::NUM_W-1:0] : rem_reg;
            dvs_next = dvs_reg >> 1;
            quo_next = {quo_reg[sfd_pkg::QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire
